// ===== design/range_remap_table_core_defines.svh =====
// ----------------------------------------------------------------------------
// Range remap table core: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RANGE_REMAP_TABLE_CORE_DEFINES_SVH
`define RANGE_REMAP_TABLE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RRT_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("range remap table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RRT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("range remap table: next-cycle check failed");

`endif

// ===== design/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// Range remap table package
// Table depth, entry record, status and operation codes, shared structs.
// ----------------------------------------------------------------------------
package rrt_pkg;

    localparam int ENTRIES = 16;
    localparam int IW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        OP_MAP    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UNMAP  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_ZERO_SIZE  = 3'd1,
        ST_OVERFLOW   = 3'd2,
        ST_COLLISION  = 3'd3,
        ST_NO_SPACE   = 3'd4,
        ST_NOT_FOUND  = 3'd5,
        ST_TABLE_FULL = 3'd6
    } status_t;

    typedef struct packed {
        logic [63:0] real_start;
        logic [63:0] length;
        logic [63:0] ident;
        logic [63:0] mapped_start;
        logic [63:0] free_after;
    } ent_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] start_addr;
        logic [63:0] range_size;
        logic [63:0] entry_id;
        logic        remove_existing;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [63:0] map_addr;
        logic [63:0] found_id;
        logic [63:0] offset;
        logic [63:0] max_mapped_length;
    } result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

endpackage

// ===== design/rrt_if.sv =====
// ----------------------------------------------------------------------------
// Range remap table channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rrt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] start_addr;
    logic [63:0] range_size;
    logic [63:0] entry_id;
    logic        remove_existing;

    modport source (output valid, operation, start_addr, range_size, entry_id,
                    remove_existing, input ready);
    modport sink   (input valid, operation, start_addr, range_size, entry_id,
                    remove_existing, output ready);
endinterface

interface rrt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] map_addr;
    logic [63:0] found_id;
    logic [63:0] offset;
    logic [63:0] max_mapped_length;

    modport source (output valid, status, map_addr, found_id, offset,
                    max_mapped_length, input ready);
    modport sink   (input valid, status, map_addr, found_id, offset,
                    max_mapped_length, output ready);
endinterface

// ===== design/rrt_mem.sv =====
// ----------------------------------------------------------------------------
// Range remap table entry store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rrt_mem
    import rrt_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  ent_t          wdata,
    input  logic [IW-1:0] raddr,
    output ent_t          rdata
);

    ent_t mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/rrt_engine.sv =====
// ----------------------------------------------------------------------------
// Range remap table sequencer
// Walks the entry store to map, look up and unmap ranges.
// ----------------------------------------------------------------------------
module rrt_engine
    import rrt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  req_t      req,
    input  logic      take,
    output result_t   res,
    output eng_stat_t stat
);

    typedef enum logic [26:0] {
        S_IDLE     = 27'h0000001,
        S_MS_RD    = 27'h0000002,
        S_MS_EV    = 27'h0000004,
        S_MS_NEED  = 27'h0000008,
        S_MS_DEL   = 27'h0000010,
        S_MS_COV   = 27'h0000020,
        S_MS_PLACE = 27'h0000040,
        S_MS_PDONE = 27'h0000080,
        S_PL_START = 27'h0000100,
        S_PL_FIRST = 27'h0000200,
        S_PL_RD    = 27'h0000400,
        S_PL_EV    = 27'h0000800,
        S_IN_SH    = 27'h0001000,
        S_IN_SHW   = 27'h0002000,
        S_RM_START = 27'h0004000,
        S_RM_A     = 27'h0008000,
        S_RM_B     = 27'h0010000,
        S_RM_SH    = 27'h0020000,
        S_RM_SHW   = 27'h0040000,
        S_LK_RD    = 27'h0080000,
        S_LK_EV    = 27'h0100000,
        S_UM_RD    = 27'h0200000,
        S_UM_EV    = 27'h0400000,
        S_SP_START = 27'h0800000,
        S_SP_A     = 27'h1000000,
        S_SP_B     = 27'h2000000,
        S_DONE     = 27'h4000000
    } state_t;

    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_NEW    = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] ndel_reg, ndel_next;
    logic [CW-1:0] cov_reg, cov_next;
    logic [ENTRIES-1:0] del_reg, del_next;
    logic cov_v_reg, cov_v_next;
    logic rm_reg, rm_next;
    logic [1:0] phase_reg, phase_next;
    logic [63:0] r_reg, r_next, n_reg, n_next, id_reg, id_next, last_reg, last_next;
    logic [63:0] gb_reg, gb_next, ga_reg, ga_next, oreal_reg, oreal_next;
    logic [63:0] oid_reg, oid_next;
    logic [63:0] p_r_reg, p_r_next, p_n_reg, p_n_next, p_id_reg, p_id_next;
    logic [63:0] place_m_reg, place_m_next, tmp_reg, tmp_next;
    status_t place_st_reg, place_st_next, st_reg, st_next;
    logic [63:0] maddr_reg, maddr_next, fid_reg, fid_next, off_reg, off_next;
    logic [63:0] span_reg, span_next;
    ent_t ins_reg, ins_next, prev_reg, prev_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    ent_t          mem_wdata, e;

    rrt_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (e)
    );

    always_comb
    begin
        logic [63:0]   e_last;
        logic [63:0]   dif;
        logic [63:0]   m;
        logic [CW-1:0] j;
        logic [CW-1:0] nxt;
        logic [CW:0]   need;
        logic          coll;
        ent_t          w;

        state_next = state_reg;
        ret_next = ret_reg;
        cnt_next = cnt_reg;
        scan_next = scan_reg;
        ptr_next = ptr_reg;
        k_next = k_reg;
        ndel_next = ndel_reg;
        cov_next = cov_reg;
        del_next = del_reg;
        cov_v_next = cov_v_reg;
        rm_next = rm_reg;
        phase_next = phase_reg;
        r_next = r_reg;
        n_next = n_reg;
        id_next = id_reg;
        last_next = last_reg;
        gb_next = gb_reg;
        ga_next = ga_reg;
        oreal_next = oreal_reg;
        oid_next = oid_reg;
        p_r_next = p_r_reg;
        p_n_next = p_n_reg;
        p_id_next = p_id_reg;
        place_m_next = place_m_reg;
        tmp_next = tmp_reg;
        place_st_next = place_st_reg;
        st_next = st_reg;
        maddr_next = maddr_reg;
        fid_next = fid_reg;
        off_next = off_reg;
        span_next = span_reg;
        ins_next = ins_reg;
        prev_next = prev_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = e;
        mem_raddr = '0;

        e_last = e.real_start + (e.length - 64'd1);
        dif = r_reg - e.real_start;
        m = e.mapped_start + e.length;
        j = scan_reg - CW'(1);
        nxt = scan_reg + CW'(1);
        coll = (e.length != 64'd0) && (e.real_start <= last_reg) && (r_reg <= e_last);
        need = {1'b0, cnt_reg} - {1'b0, ndel_reg}
             + (cov_v_reg ? ((CW+1)'(gb_reg != 64'd0) + (CW+1)'(ga_reg != 64'd0))
                          : (CW+1)'(1));
        w = e;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    r_next = req.start_addr;
                    n_next = req.range_size;
                    id_next = req.entry_id;
                    rm_next = req.remove_existing;
                    last_next = req.start_addr + (req.range_size - 64'd1);
                    maddr_next = '0;
                    fid_next = '0;
                    off_next = '0;
                    st_next = ST_NOT_FOUND;
                    scan_next = '0;
                    case (req.operation)
                        OP_MAP:
                        begin
                            if (req.range_size == 64'd0)
                            begin
                                st_next = ST_ZERO_SIZE;
                                state_next = S_SP_START;
                            end
                            else if ((req.range_size - 64'd1) > ~req.start_addr)
                            begin
                                st_next = ST_OVERFLOW;
                                state_next = S_SP_START;
                            end
                            else
                            begin
                                cov_v_next = 1'b0;
                                del_next = '0;
                                ndel_next = '0;
                                gb_next = '0;
                                ga_next = '0;
                                state_next = (cnt_reg == '0) ? S_MS_NEED : S_MS_RD;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            state_next = (cnt_reg == '0) ? S_SP_START : S_LK_RD;
                        end
                        OP_UNMAP:
                        begin
                            state_next = (cnt_reg == '0) ? S_SP_START : S_UM_RD;
                        end
                        default:
                        begin
                            state_next = S_SP_START;
                        end
                    endcase
                end
            end
            S_MS_RD:
            begin
                mem_raddr = scan_reg[IW-1:0];
                state_next = S_MS_EV;
            end
            S_MS_EV:
            begin
                state_next = (nxt == cnt_reg) ? S_MS_NEED : S_MS_RD;
                scan_next = nxt;
                if (coll)
                begin
                    if (!cov_v_reg && (e.real_start <= r_reg) && (e_last >= last_reg)
                        && (e.length > n_reg))
                    begin
                        cov_v_next = 1'b1;
                        cov_next = scan_reg;
                        gb_next = dif;
                        ga_next = e_last - last_reg;
                        oreal_next = e.real_start;
                        oid_next = e.ident;
                    end
                    else if (!rm_reg)
                    begin
                        st_next = ST_COLLISION;
                        state_next = S_SP_START;
                    end
                    else
                    begin
                        del_next[scan_reg[IW-1:0]] = 1'b1;
                        ndel_next = ndel_reg + CW'(1);
                    end
                end
            end
            S_MS_NEED:
            begin
                if (need > (CW+1)'(ENTRIES))
                begin
                    st_next = ST_TABLE_FULL;
                    state_next = S_SP_START;
                end
                else
                begin
                    scan_next = cnt_reg;
                    state_next = S_MS_DEL;
                end
            end
            S_MS_DEL:
            begin
                // Deletions go from the top down so lower indexes stay put.
                if (scan_reg == '0)
                begin
                    state_next = S_MS_COV;
                end
                else
                begin
                    scan_next = j;
                    if (del_reg[j[IW-1:0]])
                    begin
                        if (cov_v_reg && (cov_reg > j))
                        begin
                            cov_next = cov_reg - CW'(1);
                        end
                        k_next = j;
                        ret_next = S_MS_DEL;
                        state_next = S_RM_START;
                    end
                end
            end
            S_MS_COV:
            begin
                if (cov_v_reg)
                begin
                    k_next = cov_reg;
                    ret_next = S_MS_PLACE;
                    phase_next = (gb_reg != 64'd0) ? PH_BEFORE : PH_NEW;
                    state_next = S_RM_START;
                end
                else
                begin
                    phase_next = PH_NEW;
                    state_next = S_MS_PLACE;
                end
            end
            S_MS_PLACE:
            begin
                case (phase_reg)
                    PH_BEFORE:
                    begin
                        p_r_next = oreal_reg;
                        p_n_next = gb_reg;
                        p_id_next = oid_reg;
                    end
                    PH_NEW:
                    begin
                        p_r_next = r_reg;
                        p_n_next = n_reg;
                        p_id_next = id_reg;
                    end
                    default:
                    begin
                        p_r_next = last_reg + 64'd1;
                        p_n_next = ga_reg;
                        p_id_next = oid_reg;
                    end
                endcase
                state_next = S_PL_START;
            end
            S_MS_PDONE:
            begin
                if (place_st_reg != ST_OK)
                begin
                    st_next = place_st_reg;
                    maddr_next = '0;
                    state_next = S_SP_START;
                end
                else
                begin
                    case (phase_reg)
                        PH_BEFORE:
                        begin
                            phase_next = PH_NEW;
                            state_next = S_MS_PLACE;
                        end
                        PH_NEW:
                        begin
                            maddr_next = place_m_reg;
                            if (cov_v_reg && (ga_reg != 64'd0))
                            begin
                                phase_next = PH_AFTER;
                                state_next = S_MS_PLACE;
                            end
                            else
                            begin
                                st_next = ST_OK;
                                state_next = S_SP_START;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                            state_next = S_SP_START;
                        end
                    endcase
                end
            end
            S_PL_START:
            begin
                if (cnt_reg >= CW'(ENTRIES))
                begin
                    place_st_next = ST_TABLE_FULL;
                    state_next = S_MS_PDONE;
                end
                else if (cnt_reg == '0)
                begin
                    ins_next = '{real_start: p_r_reg, length: p_n_reg, ident: p_id_reg,
                                 mapped_start: 64'd0, free_after: ~p_n_reg};
                    k_next = '0;
                    ptr_next = cnt_reg;
                    place_m_next = '0;
                    state_next = S_IN_SH;
                end
                else
                begin
                    mem_raddr = '0;
                    state_next = S_PL_FIRST;
                end
            end
            S_PL_FIRST:
            begin
                if (e.mapped_start >= p_n_reg)
                begin
                    ins_next = '{real_start: p_r_reg, length: p_n_reg, ident: p_id_reg,
                                 mapped_start: 64'd0,
                                 free_after: e.mapped_start - p_n_reg};
                    k_next = '0;
                    ptr_next = cnt_reg;
                    place_m_next = '0;
                    state_next = S_IN_SH;
                end
                else
                begin
                    scan_next = '0;
                    state_next = S_PL_RD;
                end
            end
            S_PL_RD:
            begin
                mem_raddr = scan_reg[IW-1:0];
                state_next = S_PL_EV;
            end
            S_PL_EV:
            begin
                if (e.free_after >= p_n_reg)
                begin
                    // The gap moves from this entry to the new one behind it.
                    w.free_after = 64'd0;
                    mem_we = 1'b1;
                    mem_waddr = scan_reg[IW-1:0];
                    mem_wdata = w;
                    ins_next = '{real_start: p_r_reg, length: p_n_reg, ident: p_id_reg,
                                 mapped_start: m, free_after: e.free_after - p_n_reg};
                    k_next = nxt;
                    ptr_next = cnt_reg;
                    place_m_next = m;
                    state_next = S_IN_SH;
                end
                else
                begin
                    scan_next = nxt;
                    if (nxt == cnt_reg)
                    begin
                        place_st_next = ST_NO_SPACE;
                        state_next = S_MS_PDONE;
                    end
                    else
                    begin
                        state_next = S_PL_RD;
                    end
                end
            end
            S_IN_SH:
            begin
                if (ptr_reg > k_reg)
                begin
                    mem_raddr = IW'(ptr_reg - CW'(1));
                    state_next = S_IN_SHW;
                end
                else
                begin
                    mem_we = 1'b1;
                    mem_waddr = k_reg[IW-1:0];
                    mem_wdata = ins_reg;
                    cnt_next = cnt_reg + CW'(1);
                    place_st_next = ST_OK;
                    state_next = S_MS_PDONE;
                end
            end
            S_IN_SHW:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg[IW-1:0];
                mem_wdata = e;
                ptr_next = ptr_reg - CW'(1);
                state_next = S_IN_SH;
            end
            S_RM_START:
            begin
                if (k_reg != '0)
                begin
                    mem_raddr = IW'(k_reg - CW'(1));
                    state_next = S_RM_A;
                end
                else
                begin
                    ptr_next = k_reg;
                    state_next = S_RM_SH;
                end
            end
            S_RM_A:
            begin
                prev_next = e;
                mem_raddr = k_reg[IW-1:0];
                state_next = S_RM_B;
            end
            S_RM_B:
            begin
                // The removed entry's space is handed to the one before it.
                w = prev_reg;
                w.free_after = prev_reg.free_after + e.length + e.free_after;
                mem_we = 1'b1;
                mem_waddr = IW'(k_reg - CW'(1));
                mem_wdata = w;
                ptr_next = k_reg;
                state_next = S_RM_SH;
            end
            S_RM_SH:
            begin
                if ((ptr_reg + CW'(1)) < cnt_reg)
                begin
                    mem_raddr = IW'(ptr_reg + CW'(1));
                    state_next = S_RM_SHW;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                    state_next = ret_reg;
                end
            end
            S_RM_SHW:
            begin
                mem_we = 1'b1;
                mem_waddr = ptr_reg[IW-1:0];
                mem_wdata = e;
                ptr_next = ptr_reg + CW'(1);
                state_next = S_RM_SH;
            end
            S_LK_RD:
            begin
                mem_raddr = scan_reg[IW-1:0];
                state_next = S_LK_EV;
            end
            S_LK_EV:
            begin
                if ((e.length != 64'd0) && (r_reg >= e.real_start)
                    && (dif <= (e.length - 64'd1)))
                begin
                    off_next = dif;
                    maddr_next = e.mapped_start + dif;
                    fid_next = e.ident;
                    st_next = ST_OK;
                    state_next = S_SP_START;
                end
                else
                begin
                    scan_next = nxt;
                    state_next = (nxt == cnt_reg) ? S_SP_START : S_LK_RD;
                end
            end
            S_UM_RD:
            begin
                mem_raddr = scan_reg[IW-1:0];
                state_next = S_UM_EV;
            end
            S_UM_EV:
            begin
                if ((e.real_start == r_reg) && (e.length == n_reg))
                begin
                    k_next = scan_reg;
                    ret_next = S_SP_START;
                    st_next = ST_OK;
                    state_next = S_RM_START;
                end
                else
                begin
                    scan_next = nxt;
                    state_next = (nxt == cnt_reg) ? S_SP_START : S_UM_RD;
                end
            end
            S_SP_START:
            begin
                if (cnt_reg == '0)
                begin
                    span_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr = IW'(cnt_reg - CW'(1));
                    state_next = S_SP_A;
                end
            end
            S_SP_A:
            begin
                tmp_next = m;
                mem_raddr = '0;
                state_next = S_SP_B;
            end
            S_SP_B:
            begin
                span_next = tmp_reg - e.mapped_start;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            cnt_reg <= '0;
            del_reg <= '0;
            cov_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            cnt_reg <= cnt_next;
            del_reg <= del_next;
            cov_v_reg <= cov_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        ptr_reg <= ptr_next;
        k_reg <= k_next;
        ndel_reg <= ndel_next;
        cov_reg <= cov_next;
        rm_reg <= rm_next;
        phase_reg <= phase_next;
        r_reg <= r_next;
        n_reg <= n_next;
        id_reg <= id_next;
        last_reg <= last_next;
        gb_reg <= gb_next;
        ga_reg <= ga_next;
        oreal_reg <= oreal_next;
        oid_reg <= oid_next;
        p_r_reg <= p_r_next;
        p_n_reg <= p_n_next;
        p_id_reg <= p_id_next;
        place_m_reg <= place_m_next;
        tmp_reg <= tmp_next;
        place_st_reg <= place_st_next;
        st_reg <= st_next;
        maddr_reg <= maddr_next;
        fid_reg <= fid_next;
        off_reg <= off_next;
        span_reg <= span_next;
        ins_reg <= ins_next;
        prev_reg <= prev_next;
    end

    assign res = '{status: st_reg, map_addr: maddr_reg, found_id: fid_reg,
                   offset: off_reg, max_mapped_length: span_reg};
    assign stat = '{idle: state_reg == S_IDLE, done: state_reg == S_DONE};

endmodule

// ===== design/range_remap_table_core.sv =====
// ----------------------------------------------------------------------------
// Range remap table core
// Sequence: a lookup reads the entries in order until one holds the address;
// an unmap reads them until the exact range matches, then moves every later
// entry down. A map scans the entries for collisions, then moves entries for
// each delete and insert. Every item ends by working out the mapped span.
// Throughput: one item at a time; a new item is taken only while idle.
// Reset: the table is empty after reset; the entry store needs no clearing.
// ----------------------------------------------------------------------------
`include "range_remap_table_core_defines.svh"

module range_remap_table_core
    import rrt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rrt_req_if.sink  req,
    rrt_rsp_if.source rsp
);

    // The sequencer keeps the table in one synchronous store. Every step
    // either reads an entry and evaluates it in the following cycle, or
    // writes one; no state reads and writes the store at once, so a read
    // always sees the data written before it and no forwarding is needed.

    req_t      req_item;
    result_t   eng_res;
    eng_stat_t stat;
    logic      take;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    assign req_item = '{operation: req.operation, start_addr: req.start_addr,
                        range_size: req.range_size, entry_id: req.entry_id,
                        remove_existing: req.remove_existing};

    // A new item is taken whenever the sequencer is idle, even while the
    // previous result still sits in the output register.
    assign req.ready = stat.idle;

    // A finished result moves into the output register once it is free or draining.
    assign take = stat.done && (!out_valid_reg || rsp.ready);

    rrt_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (req.valid && req.ready),
        .req   (req_item),
        .take  (take),
        .res   (eng_res),
        .stat  (stat)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_res_reg.status;
    assign rsp.map_addr = out_res_reg.map_addr;
    assign rsp.found_id = out_res_reg.found_id;
    assign rsp.offset = out_res_reg.offset;
    assign rsp.max_mapped_length = out_res_reg.max_mapped_length;

    // An accepted item always starts work in the sequencer.
    `RRT_ASSERT_NEXT(a_accept_starts, clk, rst_n, req.valid && req.ready, !stat.idle)
    // A finished result waits in the sequencer until the output takes it.
    `RRT_ASSERT_NEXT(a_result_held, clk, rst_n, stat.done && !take, stat.done)
    // A result is handed over only into a free or draining output register.
    `RRT_ASSERT_SAME(a_take_free, clk, rst_n, take, !out_valid_reg || rsp.ready)

endmodule

// ===== bench/range_remap_table_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range remap table core testbench
// Drives map, lookup and unmap items into the core through random idling on
// both channels. A scoreboard class keeps its own copy of the table, predicts
// each response and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module range_remap_table_core_test;
    import rrt_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 3000;

    logic clk;
    logic rst_n;

    rrt_req_if req ();
    rrt_rsp_if rsp ();

    range_remap_table_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // The scoreboard owns a private copy of the range table. Each accepted
    // request is applied to it at once, and the predicted response is queued
    // until the core's response for that item arrives.
    class remap_scoreboard;
        logic [63:0] real_start [ENTRIES];
        logic [63:0] length     [ENTRIES];
        logic [63:0] ident      [ENTRIES];
        logic [63:0] mstart     [ENTRIES];
        logic [63:0] free_after [ENTRIES];
        int          count;
        result_t     pending_rsp [$];
        int          mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function void drop_entry(int k);
            if (k >= count)
                return;
            if (k > 0)
                free_after[k-1] += length[k] + free_after[k];
            for (int i = k; i + 1 < count; i++)
            begin
                real_start[i] = real_start[i+1];
                length[i]     = length[i+1];
                ident[i]      = ident[i+1];
                mstart[i]     = mstart[i+1];
                free_after[i] = free_after[i+1];
            end
            count--;
        endfunction

        function void add_entry(int k, logic [63:0] r, logic [63:0] n,
                                logic [63:0] id, logic [63:0] m, logic [63:0] f);
            if (count >= ENTRIES || k > count)
                return;
            for (int i = count; i > k; i--)
            begin
                real_start[i] = real_start[i-1];
                length[i]     = length[i-1];
                ident[i]      = ident[i-1];
                mstart[i]     = mstart[i-1];
                free_after[i] = free_after[i-1];
            end
            real_start[k] = r;
            length[k]     = n;
            ident[k]      = id;
            mstart[k]     = m;
            free_after[k] = f;
            count++;
        endfunction

        function logic [63:0] last_byte(int i);
            return real_start[i] + (length[i] - 64'd1);
        endfunction

        // First fit in mapped space: the leading gap, then the gap after
        // each entry in mapped order.
        function status_t first_fit(logic [63:0] r, logic [63:0] n,
                                    logic [63:0] id, output logic [63:0] m);
            logic [63:0] f;
            m = '0;
            if (count >= ENTRIES)
                return ST_TABLE_FULL;
            if (count == 0)
            begin
                add_entry(0, r, n, id, 64'd0, ~64'd0 - n);
                return ST_OK;
            end
            if (mstart[0] >= n)
            begin
                add_entry(0, r, n, id, 64'd0, mstart[0] - n);
                return ST_OK;
            end
            for (int i = 0; i < count; i++)
            begin
                if (free_after[i] < n)
                    continue;
                m = mstart[i] + length[i];
                f = free_after[i] - n;
                free_after[i] = '0;
                add_entry(i + 1, r, n, id, m, f);
                return ST_OK;
            end
            return ST_NO_SPACE;
        endfunction

        function status_t map_range(logic [63:0] r, logic [63:0] n, logic [63:0] id,
                                    logic rm, output logic [63:0] m);
            logic        doomed [ENTRIES];
            int          ndel;
            int          need;
            int          cov;
            logic [63:0] last;
            logic [63:0] gb;
            logic [63:0] ga;
            logic [63:0] oreal;
            logic [63:0] oid;
            logic [63:0] scratch;
            status_t     st;
            m    = '0;
            ndel = 0;
            cov  = -1;
            gb   = '0;
            ga   = '0;
            if (n == 0)
                return ST_ZERO_SIZE;
            if (n - 64'd1 > ~r)
                return ST_OVERFLOW;
            last = r + (n - 64'd1);
            for (int i = 0; i < ENTRIES; i++)
                doomed[i] = 1'b0;
            for (int i = 0; i < count; i++)
            begin
                if (length[i] == 0)
                    continue;
                if (!(real_start[i] <= last && r <= last_byte(i)))
                    continue;
                // The first strictly larger entry that covers the range is split.
                if (cov < 0 && real_start[i] <= r && last_byte(i) >= last &&
                    length[i] > n)
                begin
                    cov = i;
                    continue;
                end
                if (!rm)
                    return ST_COLLISION;
                doomed[i] = 1'b1;
                ndel++;
            end
            need = count - ndel + 1;
            if (cov >= 0)
            begin
                gb   = r - real_start[cov];
                ga   = last_byte(cov) - last;
                need = need - 1 + (gb != 0) + (ga != 0);
            end
            if (need > ENTRIES)
                return ST_TABLE_FULL;
            for (int i = count; i > 0; i--)
            begin
                if (!doomed[i-1])
                    continue;
                if (cov > i - 1)
                    cov--;
                drop_entry(i - 1);
            end
            if (cov >= 0)
            begin
                oreal = real_start[cov];
                oid   = ident[cov];
                drop_entry(cov);
                if (gb != 0)
                begin
                    st = first_fit(oreal, gb, oid, scratch);
                    if (st != ST_OK)
                        return st;
                end
                st = first_fit(r, n, id, m);
                if (st != ST_OK)
                    return st;
                if (ga != 0)
                begin
                    st = first_fit(last + 64'd1, ga, oid, scratch);
                    if (st != ST_OK)
                        return st;
                end
                return ST_OK;
            end
            return first_fit(r, n, id, m);
        endfunction

        function void note_request(req_t item);
            result_t     res;
            logic [63:0] m;
            int          l;
            res        = '0;
            res.status = ST_NOT_FOUND;
            case (item.operation)
                OP_MAP:
                begin
                    res.status = map_range(item.start_addr, item.range_size, item.entry_id,
                                           item.remove_existing, m);
                    if (res.status == ST_OK)
                        res.map_addr = m;
                end
                OP_LOOKUP:
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        if (length[i] == 0 || item.start_addr < real_start[i])
                            continue;
                        if (item.start_addr - real_start[i] > length[i] - 64'd1)
                            continue;
                        res.offset   = item.start_addr - real_start[i];
                        res.map_addr = mstart[i] + res.offset;
                        res.found_id = ident[i];
                        res.status   = ST_OK;
                        break;
                    end
                end
                OP_UNMAP:
                begin
                    for (int i = 0; i < count; i++)
                    begin
                        if (real_start[i] == item.start_addr && length[i] == item.range_size)
                        begin
                            drop_entry(i);
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
                default:
                    res.status = ST_NOT_FOUND;
            endcase
            if (count > 0)
            begin
                l = count - 1;
                res.max_mapped_length = mstart[l] + length[l] - mstart[0];
            end
            pending_rsp = {pending_rsp, res};
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_response(result_t got);
            result_t want;
            if (pending_rsp.size() == 0)
            begin
                report("unexpected response", 64'(got.status), 64'd0);
                return;
            end
            want = pending_rsp[0];
            pending_rsp.delete(0);
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.map_addr !== want.map_addr)
                report("map_addr", got.map_addr, want.map_addr);
            if (got.found_id !== want.found_id)
                report("found_id", got.found_id, want.found_id);
            if (got.offset !== want.offset)
                report("offset", got.offset, want.offset);
            if (got.max_mapped_length !== want.max_mapped_length)
                report("max_mapped_length", got.max_mapped_length, want.max_mapped_length);
        endtask
    endclass

    remap_scoreboard table_sb;

    // Idle percentages; the stimulus process changes them between phases.
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Response side: check every item accepted at this edge, then choose
    // ready for the next cycle. Reads here see the values from before the
    // edge, since both sides drive with nonblocking assignments.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                table_sb.check_response({status_t'(rsp.status), rsp.map_addr,
                                         rsp.found_id, rsp.offset,
                                         rsp.max_mapped_length});
            if ((rsp.valid && rsp.ready) || (req.valid && req.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // A run that stops moving items for too long is a hang.
    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("range_remap_table_core verification failed");
            $finish;
        end
    end

    // Offers one item and holds it until the core takes it. Valid stays
    // high into the next item unless the sender decides to idle first.
    task send_item(op_t op, logic [63:0] addr, logic [63:0] size,
                   logic [63:0] id, logic rm);
        req_t item;
        item = {op, addr, size, id, rm};
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.operation       <= item.operation;
        req.start_addr      <= addr;
        req.range_size      <= size;
        req.entry_id        <= id;
        req.remove_existing <= rm;
        do
            @(posedge clk);
        while (!req.ready);
        table_sb.note_request(item);
    endtask

    function logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Picks an id: usually random, sometimes the all-ones "none given" id.
    function logic [63:0] pick_id();
        return ($urandom_range(7) == 0) ? ~64'd0 : rand64();
    endfunction

    // Most random items work in a small window of real addresses so that
    // collisions, splits, deletions and full tables keep happening. The rest
    // is noise over the whole field range, including the unused code.
    task send_random_item();
        int          pick;
        int          k;
        logic [63:0] base;
        base = 64'h0000_0000_0001_0000;
        pick = $urandom_range(99);
        if (pick < 40)
            send_item(OP_MAP, base + 64'($urandom_range(1023)),
                      64'($urandom_range(1, 96)), pick_id(), 1'($urandom_range(1)));
        else if (pick < 60)
            send_item(OP_LOOKUP, base + 64'($urandom_range(1100)), rand64(), rand64(),
                      1'($urandom_range(1)));
        else if (pick < 80 && table_sb.count > 0)
        begin
            k = $urandom_range(table_sb.count - 1);
            send_item(OP_UNMAP, table_sb.real_start[k], table_sb.length[k], rand64(),
                      1'($urandom_range(1)));
        end
        else if (pick < 85)
            send_item(OP_UNMAP, base + 64'($urandom_range(1023)),
                      64'($urandom_range(96)), rand64(), 1'($urandom_range(1)));
        else if (pick < 90)
            send_item(OP_MAP, rand64(), rand64() >> $urandom_range(63), pick_id(),
                      1'($urandom_range(1)));
        else
            send_item(op_t'($urandom_range(3)), rand64(), rand64(), rand64(),
                      1'($urandom_range(1)));
    endtask

    initial
    begin
        table_sb            = new();
        send_idle_pct       = 0;
        recv_idle_pct       = 0;
        quiet_cycles        = 0;
        rst_n               = 1'b0;
        req.valid           = 1'b0;
        req.operation       = OP_MAP;
        req.start_addr      = '0;
        req.range_size      = '0;
        req.entry_id        = '0;
        req.remove_existing = 1'b0;
        rsp.ready           = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: bad sizes, the top of the address space, a split,
        // collisions with and without removal, no space, misses, the unused
        // operation code and a full table.
        send_idle_pct = 14;
        recv_idle_pct = 83;
        send_item(OP_MAP, 64'h100, 64'd0, 64'd5, 1'b0);
        send_item(OP_MAP, ~64'd0, 64'd2, 64'd5, 1'b0);
        send_item(OP_MAP, ~64'd0, 64'd1, 64'd6, 1'b0);
        send_item(OP_LOOKUP, ~64'd0, 64'd0, 64'd0, 1'b0);
        send_item(OP_MAP, 64'h1000, 64'h100, 64'd1, 1'b0);
        send_item(OP_MAP, 64'h1040, 64'h10, 64'd2, 1'b0);
        send_item(OP_LOOKUP, 64'h1045, 64'd0, 64'd0, 1'b0);
        send_item(OP_LOOKUP, 64'h10f0, 64'd0, 64'd0, 1'b0);
        send_item(OP_MAP, 64'h0ff0, 64'h20, 64'd3, 1'b0);
        send_item(OP_MAP, 64'h0ff0, 64'h20, ~64'd0, 1'b1);
        send_item(OP_MAP, 64'd0, ~64'd0, 64'd4, 1'b0);
        send_item(OP_MAP, 64'd0, ~64'd0, 64'd4, 1'b1);
        send_item(OP_UNMAP, 64'd0, ~64'd0, 64'd0, 1'b0);
        send_item(OP_UNMAP, ~64'd0, 64'd1, 64'd0, 1'b0);
        send_item(OP_MAP, 64'd0, 64'h8000_0000_0000_0000, 64'd7, 1'b0);
        send_item(OP_MAP, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                  64'd8, 1'b0);
        send_item(OP_UNMAP, 64'd0, 64'h8000_0000_0000_0000, 64'd0, 1'b0);
        send_item(OP_UNMAP, 64'd0, 64'd0, 64'd0, 1'b0);
        send_item(OP_LOOKUP, 64'h5, 64'd0, 64'd0, 1'b1);
        send_item(op_t'(2'd3), ~64'd0, ~64'd0, ~64'd0, 1'b1);
        for (int i = 0; i < 17; i++)
            send_item(OP_MAP, 64'h2000 + 64'(i) * 64'h40, 64'h20, 64'(i), 1'b0);
        send_item(OP_MAP, 64'h2008, 64'h8, 64'd9, 1'b1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 14;
            end
            if (i == RANDOM_ITEMS / 2)
            begin
                // Let the core run dry before offering anything more.
                req.valid <= 1'b0;
                while (table_sb.pending_rsp.size() != 0)
                    @(posedge clk);
            end
            if (i == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random_item();
        end
        req.valid <= 1'b0;

        while (table_sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (table_sb.mismatches == 0 && table_sb.pending_rsp.size() == 0)
            $display("range_remap_table_core verification clean");
        else
            $display("range_remap_table_core verification failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+design
design/rrt_pkg.sv
design/rrt_if.sv
design/rrt_mem.sv
design/rrt_engine.sv
design/range_remap_table_core.sv
bench/range_remap_table_core_test.sv
